// File: hw/rtl/bfb_pkg.sv
package bfb_pkg;

    // Default geometry of the font and the framebuffer.
    localparam int GLYPH_ROWS_DEF  = 10;
    localparam int LINE_PITCH_DEF  = 320;
    localparam int GLYPH_SLOTS_DEF = 256;

    // Field widths fixed by the item formats.
    localparam int REQ_W    = 3;
    localparam int ADDR_W   = 16;
    localparam int POS_Y_W  = 8;
    localparam int COLOR_W  = 8;
    localparam int CODE_W   = 8;
    localparam int INDEX_W  = 12;
    localparam int DATA_W   = 16;
    localparam int MASK_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 56;

    // Request kinds carried in the slave-side tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_START    = 3'd0,
        REQ_CHAR     = 3'd1,
        REQ_LD_MAP   = 3'd2,
        REQ_LD_ADV   = 3'd3,
        REQ_LD_GLYPH = 3'd4
    } t_req;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUFFER_BASE = 2'd0,
        CFG_BAND_TOP    = 2'd1,
        CFG_BAND_BOTTOM = 2'd2
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;        // latch pen, colour, clip flag; clear width
        logic map_rd;       // read the character map at the incoming code
        logic ld_map;       // write the character map
        logic ld_adv;       // write the advance table
        logic ld_glyph;     // write a glyph row
        logic glyph_fetch;  // read advance and first glyph row
        logic width_upd;    // add the advance to the width, prime row address
        logic row_next;     // current row has been transferred
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic code_zero;
        logic clipped;
        logic last_row;
    } t_dp_stat;

endpackage

// File: hw/rtl/bitmap_font_text_blitter_core.sv
// Text blitter for a byte-per-pixel framebuffer with 16-pixel-wide glyphs.
// Requests arrive as transfers on the slave stream: tuser carries the
// request kind (start string, character, or a load of the character map,
// the advance table or a glyph row) and tdata carries the other fields.
// Each drawn character leaves as GLYPH_ROWS transfers on the master
// stream, one per glyph row, with tlast set on the final row.
// A separate write channel sets the framebuffer base and the clipping band;
// it is always ready and should only be used while no character is in flight.
// Start, load and ignored items are accepted without stalling. A drawn
// character first reads the character map, then the advance table and the
// first glyph row, then updates the running width, and then sends one row
// per cycle while the receiver is ready, as the single glyph memory port
// delivers one row a cycle.
// The slave side is not ready while a character's rows are being sent.
// When the receiver stalls, the current row is held in the output registers
// and the next glyph row is read only after the transfer completes.
// Reset (synchronous, active low) clears the pen, width and colour, marks
// the string as clipped and restores the default band; the font stores are
// not cleared and must be loaded before use.
module bitmap_font_text_blitter_core #(
    parameter int GLYPH_ROWS  = bfb_pkg::GLYPH_ROWS_DEF,
    parameter int LINE_PITCH  = bfb_pkg::LINE_PITCH_DEF,
    parameter int GLYPH_SLOTS = bfb_pkg::GLYPH_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pos_x[15:0], pos_y[23:16], ink[31:24], char_code[39:32],
    // table_index[51:40], table_data[67:52], zero padding [71:68]
    input  logic [bfb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // req_type[2:0]
    input  logic [bfb_pkg::REQ_W-1:0]       s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // row_address[15:0], pixel_mask[31:16], pixel_color[39:32],
    // text_width[55:40]
    output logic [bfb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bfb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bfb_pkg::DATA_W-1:0]      i_cfg_data
);

    bfb_pkg::t_dp_cmd  w_cmd;
    bfb_pkg::t_dp_stat w_stat;

    logic [bfb_pkg::ADDR_W-1:0]  w_row_address;
    logic [bfb_pkg::MASK_W-1:0]  w_pixel_mask;
    logic [bfb_pkg::COLOR_W-1:0] w_pixel_color;
    logic [bfb_pkg::ADDR_W-1:0]  w_text_width;

    // Configuration writes complete in the cycle they are presented.
    assign o_cfg_ready = 1'b1;

    bfb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_req     (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    bfb_datapath #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .LINE_PITCH  (LINE_PITCH),
        .GLYPH_SLOTS (GLYPH_SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pos_x       (s_axis_tdata[15:0]),
        .i_pos_y       (s_axis_tdata[23:16]),
        .i_ink         (s_axis_tdata[31:24]),
        .i_char_code   (s_axis_tdata[39:32]),
        .i_table_index (s_axis_tdata[51:40]),
        .i_table_data  (s_axis_tdata[67:52]),
        .o_row_address (w_row_address),
        .o_pixel_mask  (w_pixel_mask),
        .o_pixel_color (w_pixel_color),
        .o_text_width  (w_text_width)
    );

    // The row flag comes straight from the datapath's row counter.
    assign m_axis_tlast = w_stat.last_row;
    assign m_axis_tdata = {w_text_width, w_pixel_color, w_pixel_mask, w_row_address};

endmodule

// File: hw/rtl/bfb_ctrl.sv
module bfb_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_valid,
    input  logic [bfb_pkg::REQ_W-1:0] i_req,
    output logic                    o_s_ready,
    output logic                    o_m_valid,
    input  logic                    i_m_ready,
    input  bfb_pkg::t_dp_stat       i_stat,
    output bfb_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_LOAD,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_s_ready;
    logic   r_m_valid;
    logic   w_accept;
    logic   w_draw;
    logic   w_is_char;

    assign w_accept  = i_s_valid && r_s_ready;
    assign w_is_char = (i_req == bfb_pkg::REQ_CHAR);
    assign w_draw    = w_is_char && !i_stat.code_zero && !i_stat.clipped;

    always_comb begin
        o_cmd = '0;
        if (w_accept) begin
            unique case (i_req)
                bfb_pkg::REQ_START:    o_cmd.start    = 1'b1;
                bfb_pkg::REQ_CHAR:     o_cmd.map_rd   = w_draw;
                bfb_pkg::REQ_LD_MAP:   o_cmd.ld_map   = 1'b1;
                bfb_pkg::REQ_LD_ADV:   o_cmd.ld_adv   = 1'b1;
                bfb_pkg::REQ_LD_GLYPH: o_cmd.ld_glyph = 1'b1;
                default: ;
            endcase
        end
        o_cmd.glyph_fetch = (r_state == ST_MAP);
        o_cmd.width_upd   = (r_state == ST_LOAD);
        o_cmd.row_next    = (r_state == ST_EMIT) && r_m_valid && i_m_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_s_ready <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && w_draw) begin
                        r_state   <= ST_MAP;
                        r_s_ready <= 1'b0;
                    end
                end
                ST_MAP: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_state   <= ST_EMIT;
                    r_m_valid <= 1'b1;
                end
                ST_EMIT: begin
                    if (o_cmd.row_next && i_stat.last_row) begin
                        r_state   <= ST_IDLE;
                        r_m_valid <= 1'b0;
                        r_s_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_ready = r_s_ready;
    assign o_m_valid = r_m_valid;

endmodule

// File: hw/rtl/bfb_datapath.sv
module bfb_datapath #(
    parameter int GLYPH_ROWS  = bfb_pkg::GLYPH_ROWS_DEF,
    parameter int LINE_PITCH  = bfb_pkg::LINE_PITCH_DEF,
    parameter int GLYPH_SLOTS = bfb_pkg::GLYPH_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfb_pkg::t_dp_cmd              i_cmd,
    output bfb_pkg::t_dp_stat             o_stat,
    input  logic                          i_cfg_valid,
    input  logic [bfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bfb_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic [bfb_pkg::ADDR_W-1:0]    i_pos_x,
    input  logic [bfb_pkg::POS_Y_W-1:0]   i_pos_y,
    input  logic [bfb_pkg::COLOR_W-1:0]   i_ink,
    input  logic [bfb_pkg::CODE_W-1:0]    i_char_code,
    input  logic [bfb_pkg::INDEX_W-1:0]   i_table_index,
    input  logic [bfb_pkg::DATA_W-1:0]    i_table_data,
    output logic [bfb_pkg::ADDR_W-1:0]    o_row_address,
    output logic [bfb_pkg::MASK_W-1:0]    o_pixel_mask,
    output logic [bfb_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic [bfb_pkg::ADDR_W-1:0]    o_text_width
);

    localparam int StoreRows = GLYPH_SLOTS * GLYPH_ROWS;
    localparam int StoreW    = $clog2(StoreRows);
    localparam int RowW      = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam int PitchW    = $clog2(LINE_PITCH + 1);
    localparam int ProdW     = PitchW + bfb_pkg::POS_Y_W;
    localparam int ClipW     = bfb_pkg::POS_Y_W + 1;
    localparam int MapDepth  = 256;
    localparam int BW        = bfb_pkg::BYTE_W;
    localparam int AW        = bfb_pkg::ADDR_W;

    // Configuration registers.
    logic [AW-1:0] r_base;
    logic [BW-1:0] r_top;
    logic [BW-1:0] r_bottom;

    // String state.
    logic [AW-1:0]                  r_pen;
    logic [AW-1:0]                  r_width;
    logic [bfb_pkg::COLOR_W-1:0]    r_color;
    logic                           r_clipped;

    // Per-character working registers.
    logic [BW-1:0]     r_glyph;
    logic [BW-1:0]     r_adv;
    logic [StoreW-1:0] r_gaddr;
    logic [RowW-1:0]   r_row;
    logic [AW-1:0]     r_raddr;
    logic [bfb_pkg::MASK_W-1:0] r_grow;

    // Stores.
    logic [BW-1:0]              r_map_mem   [MapDepth];
    logic [BW-1:0]              r_adv_mem   [MapDepth];
    logic [bfb_pkg::MASK_W-1:0] r_glyph_mem [StoreRows];

    logic [BW-1:0]     w_wrap [MapDepth];
    logic [ProdW-1:0]  w_prod;
    logic [AW-1:0]     w_pen_start;
    logic              w_clip;
    logic [StoreW-1:0] w_gbase;
    logic [StoreW-1:0] n_gaddr;
    logic              w_grd;
    logic [AW-1:0]     w_adv_ext;
    logic              w_last;
    logic              w_map_ok;
    logic              w_glyph_ok;

    // Glyph number wrapped into the slot range, as a constant table.
    for (genvar g = 0; g < MapDepth; g++) begin : g_wrap
        assign w_wrap[g] = BW'(g % GLYPH_SLOTS);
    end

    assign w_prod      = ProdW'(LINE_PITCH) * ProdW'(i_pos_y);
    assign w_pen_start = r_base + AW'(w_prod) + i_pos_x;
    assign w_clip      = (i_pos_y > r_bottom)
                      || (ClipW'(i_pos_y) + ClipW'(GLYPH_ROWS) <= ClipW'(r_top));

    assign w_gbase   = StoreW'(w_wrap[r_glyph]) * StoreW'(GLYPH_ROWS);
    assign w_adv_ext = {{(AW - BW){r_adv[BW-1]}}, r_adv};
    assign w_last    = (r_row == RowW'(GLYPH_ROWS - 1));

    assign w_map_ok   = (i_table_index < bfb_pkg::INDEX_W'(MapDepth));
    assign w_glyph_ok = ({1'b0, i_table_index} < (bfb_pkg::INDEX_W + 1)'(StoreRows));

    assign w_grd   = i_cmd.glyph_fetch || (i_cmd.row_next && !w_last);
    assign n_gaddr = i_cmd.glyph_fetch ? w_gbase : r_gaddr + StoreW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_top     <= '0;
            r_bottom  <= BW'(199);
            r_pen     <= '0;
            r_width   <= '0;
            r_color   <= '0;
            r_clipped <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bfb_pkg::CFG_BUFFER_BASE: r_base   <= i_cfg_data;
                    bfb_pkg::CFG_BAND_TOP:    r_top    <= i_cfg_data[BW-1:0];
                    bfb_pkg::CFG_BAND_BOTTOM: r_bottom <= i_cfg_data[BW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_pen     <= w_pen_start;
                r_color   <= i_ink;
                r_width   <= '0;
                r_clipped <= w_clip;
            end
            if (i_cmd.width_upd) begin
                r_width <= r_width + w_adv_ext;
            end
            if (i_cmd.row_next && w_last) begin
                r_pen <= r_pen + w_adv_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.width_upd) begin
            r_raddr <= r_pen;
            r_row   <= '0;
        end else if (i_cmd.row_next && !w_last) begin
            r_raddr <= r_raddr + AW'(LINE_PITCH);
            r_row   <= r_row + RowW'(1);
        end
    end

    // Character map and advance table.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_map && w_map_ok) begin
            r_map_mem[i_table_index[BW-1:0]] <= i_table_data[BW-1:0];
        end
        if (i_cmd.map_rd) begin
            r_glyph <= r_map_mem[i_char_code];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_adv && w_map_ok) begin
            r_adv_mem[i_table_index[BW-1:0]] <= i_table_data[BW-1:0];
        end
        if (i_cmd.glyph_fetch) begin
            r_adv <= r_adv_mem[r_glyph];
        end
    end

    // Glyph rows, one read per cycle while rows advance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_glyph && w_glyph_ok) begin
            r_glyph_mem[i_table_index[StoreW-1:0]] <= i_table_data;
        end
        if (w_grd) begin
            r_grow  <= r_glyph_mem[n_gaddr];
            r_gaddr <= n_gaddr;
        end
    end

    assign o_stat.code_zero = (i_char_code == '0);
    assign o_stat.clipped   = r_clipped;
    assign o_stat.last_row  = w_last;

    assign o_row_address = r_raddr;
    assign o_pixel_mask  = r_grow;
    assign o_pixel_color = r_color;
    assign o_text_width  = r_width;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the text blitter. Requests go in on the slave stream, and
// glyph rows come back on the master stream. A scoreboard object keeps its own copy
// of the font stores, the pen, the running width, the colour and the clip flag. It
// predicts every row when the request transfer is accepted. It then compares each
// row transfer with the oldest row still owed.
module testbench;

    localparam int ROWS       = bfb_pkg::GLYPH_ROWS_DEF;
    localparam int PITCH      = bfb_pkg::LINE_PITCH_DEF;
    localparam int SLOTS      = bfb_pkg::GLYPH_SLOTS_DEF;
    localparam int STORE_ROWS = SLOTS * ROWS;

    // Request kinds beyond the last defined one are to be ignored by the block.
    localparam logic [bfb_pkg::REQ_W-1:0] REQ_UNKNOWN_FIRST = bfb_pkg::REQ_LD_GLYPH + 3'd1;

    // The settle time allows for three drawn characters, which covers any
    // character that is still being worked on when the last row has gone.
    localparam int SETTLE_CYCLES  = 3 * (3 + ROWS);
    localparam int RX_HOLD_CYCLES = 150;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 30;
    // The slowest run is about 210 requests with ten rows each. Every row waits out
    // a stalled receiver, and every request waits out an idle sender. Even so, the
    // limit leaves a wide margin over such a run.
    localparam int CYCLE_LIMIT    = 300000;

    typedef struct packed {
        logic [bfb_pkg::ADDR_W-1:0]  addr;
        logic [bfb_pkg::MASK_W-1:0]  mask;
        logic [bfb_pkg::COLOR_W-1:0] color;
        logic [bfb_pkg::ADDR_W-1:0]  width;
        logic                        last;
    } t_glyph_row;

    class t_blit_scoreboard;
        t_glyph_row   rows_due[$];
        logic [15:0]  buffer_base;
        logic [7:0]   band_top;
        logic [7:0]   band_bottom;
        logic [7:0]   char_map[256];
        logic [7:0]   advance[256];
        logic [15:0]  glyph_rows[STORE_ROWS];
        bit           map_set[256];
        bit           adv_set[256];
        bit           row_set[STORE_ROWS];
        logic [15:0]  pen;
        logic [15:0]  width;
        logic [7:0]   color;
        bit           clipped;
        int           errors;
        int           strings;
        int           clipped_strings;
        int           chars_drawn;
        int           rows_checked;
        int           loads;

        function new();
            buffer_base = '0;
            band_top    = '0;
            band_bottom = 8'd199;
            pen         = '0;
            width       = '0;
            color       = '0;
            clipped     = 1'b1;
        endfunction

        function void set_reg(input bfb_pkg::t_cfg_idx idx, input logic [15:0] value);
            case (idx)
                bfb_pkg::CFG_BUFFER_BASE: buffer_base = value;
                bfb_pkg::CFG_BAND_TOP:    band_top    = value[7:0];
                bfb_pkg::CFG_BAND_BOTTOM: band_bottom = value[7:0];
                default: ;
            endcase
        endfunction

        // A code may be drawn only when its map entry, its glyph's advance and
        // all of its glyph rows have been loaded.
        function bit code_ready(input logic [7:0] code);
            logic [7:0] g;
            if (!map_set[code]) return 1'b0;
            g = char_map[code];
            if (!adv_set[g]) return 1'b0;
            for (int r = 0; r < ROWS; r++)
                if (!row_set[(g % SLOTS) * ROWS + r]) return 1'b0;
            return 1'b1;
        endfunction

        function void note_item(input logic [bfb_pkg::REQ_W-1:0] kind,
                                input logic [bfb_pkg::S_TDATA_W-1:0] p);
            logic [15:0] px;
            logic [7:0]  py;
            logic [7:0]  ink;
            logic [7:0]  code;
            logic [11:0] idx;
            logic [15:0] data;
            logic [7:0]  g;
            logic [15:0] step;
            t_glyph_row  row;
            px   = p[15:0];
            py   = p[23:16];
            ink  = p[31:24];
            code = p[39:32];
            idx  = p[51:40];
            data = p[67:52];
            case (kind)
                bfb_pkg::REQ_START: begin
                    pen     = 16'(buffer_base + PITCH * py + px);
                    color   = ink;
                    width   = '0;
                    clipped = (py > band_bottom) || (py + ROWS <= band_top);
                    strings++;
                    if (clipped) clipped_strings++;
                end
                bfb_pkg::REQ_CHAR: begin
                    if (code != 8'd0 && !clipped) begin
                        g     = char_map[code];
                        step  = {{8{advance[g][7]}}, advance[g]};
                        width = width + step;
                        for (int r = 0; r < ROWS; r++) begin
                            row.addr  = 16'(pen + r * PITCH);
                            row.mask  = glyph_rows[(g % SLOTS) * ROWS + r];
                            row.color = color;
                            row.width = width;
                            row.last  = (r == ROWS - 1);
                            rows_due.push_back(row);
                        end
                        pen = pen + step;
                        chars_drawn++;
                    end
                end
                bfb_pkg::REQ_LD_MAP: begin
                    loads++;
                    if (idx < 256) begin
                        char_map[idx[7:0]] = data[7:0];
                        map_set[idx[7:0]]  = 1'b1;
                    end
                end
                bfb_pkg::REQ_LD_ADV: begin
                    loads++;
                    if (idx < 256) begin
                        advance[idx[7:0]] = data[7:0];
                        adv_set[idx[7:0]] = 1'b1;
                    end
                end
                bfb_pkg::REQ_LD_GLYPH: begin
                    loads++;
                    if (idx < STORE_ROWS) begin
                        glyph_rows[idx] = data;
                        row_set[idx]    = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_row(input logic [bfb_pkg::M_TDATA_W-1:0] d, input logic last);
            t_glyph_row want;
            rows_checked++;
            if (rows_due.size() == 0) begin
                $error("row transfer with no character pending: tdata %h", d);
                errors++;
                return;
            end
            want = rows_due.pop_front();
            if (d[15:0] !== want.addr) begin
                $error("row_address: expected %h, got %h", want.addr, d[15:0]);
                errors++;
            end
            if (d[31:16] !== want.mask) begin
                $error("pixel_mask: expected %h, got %h", want.mask, d[31:16]);
                errors++;
            end
            if (d[39:32] !== want.color) begin
                $error("pixel_color: expected %h, got %h", want.color, d[39:32]);
                errors++;
            end
            if (d[55:40] !== want.width) begin
                $error("text_width: expected %h, got %h", want.width, d[55:40]);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_row: expected %b, got %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    // Request fields from bit 0 up: pos_x, pos_y, ink, char_code, table_index,
    // table_data, then zero padding.
    logic [bfb_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    // Request kind.
    logic [bfb_pkg::REQ_W-1:0]       s_axis_tuser = bfb_pkg::REQ_START;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // Row fields from bit 0 up: row_address, pixel_mask, pixel_color, text_width.
    logic [bfb_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [bfb_pkg::CFG_IDX_W-1:0]   i_cfg_index = bfb_pkg::CFG_BUFFER_BASE;
    logic [bfb_pkg::DATA_W-1:0]      i_cfg_data = '0;

    t_blit_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int cycle_count = 0;

    bitmap_font_text_blitter_core uut (
        .i_clk,
        .i_rst_n,
        .s_axis_tdata,
        .s_axis_tuser,
        .s_axis_tvalid,
        .s_axis_tready,
        .m_axis_tdata,
        .m_axis_tlast,
        .m_axis_tvalid,
        .m_axis_tready,
        .i_cfg_valid,
        .o_cfg_ready,
        .i_cfg_index,
        .i_cfg_data
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The run is stopped here if it stalls or runs far longer than it should.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bitmap_font_text_blitter_core verification failed");
            $finish;
        end
    end

    // Receiver side. Every row transfer is checked at the edge that completes
    // it. The ready line then follows the stall rate of the current phase. When
    // the main sequence asks for a hold-off, the line stays low for a long run
    // of cycles, which this process counts itself.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_row(m_axis_tdata, m_axis_tlast);
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic logic [bfb_pkg::S_TDATA_W-1:0] pack_req(
        input logic [15:0] px, input logic [7:0] py, input logic [7:0] ink,
        input logic [7:0] code, input logic [11:0] idx, input logic [15:0] data);
        return {{(bfb_pkg::S_TDATA_W - 68){1'b0}}, data, idx, code, ink, py, px};
    endfunction

    // Offers one request after an optional idle gap. This task lowers valid
    // only during a gap. When no gap follows, valid stays high from one
    // transfer to the next.
    task automatic offer(input logic [bfb_pkg::REQ_W-1:0] kind,
                         input logic [bfb_pkg::S_TDATA_W-1:0] payload);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= payload;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(kind, payload);
    endtask

    // Fields that a request kind does not use carry random values. The code
    // field is left at zero, whose map entry is loaded first of all.
    task automatic send_start(input logic [15:0] px, input logic [7:0] py,
                              input logic [7:0] ink);
        offer(bfb_pkg::REQ_START,
              pack_req(px, py, ink, 8'd0, 12'($urandom), 16'($urandom)));
    endtask

    task automatic send_char(input logic [7:0] code);
        offer(bfb_pkg::REQ_CHAR, pack_req(16'($urandom), 8'($urandom), 8'($urandom), code,
                                          12'($urandom), 16'($urandom)));
    endtask

    task automatic send_load(input logic [bfb_pkg::REQ_W-1:0] kind, input logic [11:0] idx,
                             input logic [15:0] data);
        offer(kind, pack_req(16'($urandom), 8'($urandom), 8'($urandom), 8'd0, idx, data));
    endtask

    task automatic cfg_write(input bfb_pkg::t_cfg_idx idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, value);
    endtask

    // The band registers get random upper bits, which the block must drop.
    task automatic write_config(input logic [15:0] base, input logic [7:0] top,
                                input logic [7:0] bottom);
        cfg_write(bfb_pkg::CFG_BUFFER_BASE, base);
        cfg_write(bfb_pkg::CFG_BAND_TOP, {8'($urandom), top});
        cfg_write(bfb_pkg::CFG_BAND_BOTTOM, {8'($urandom), bottom});
        i_cfg_valid <= 1'b0;
    endtask

    // Stops offering and waits until every predicted row has arrived. It then
    // lets the block settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.rows_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Most codes are ones that are fully loaded. Now and then a code zero is
    // chosen instead.
    function automatic logic [7:0] pick_code();
        logic [7:0] ready_codes[$];
        for (int c = 1; c < 256; c++)
            if (sb.code_ready(8'(c))) ready_codes.push_back(8'(c));
        if (ready_codes.size() == 0 || $urandom_range(99) < 6) return 8'd0;
        return ready_codes[$urandom_range(ready_codes.size() - 1)];
    endfunction

    // Rows are mostly chosen inside the drawable band. Some fall right on its
    // edges, and the rest are anywhere.
    function automatic logic [7:0] pick_row();
        int lo;
        int hi;
        int sel;
        lo  = (sb.band_top >= ROWS) ? sb.band_top - ROWS + 1 : 0;
        hi  = sb.band_bottom;
        sel = $urandom_range(99);
        if (lo > hi || sel < 15) return 8'($urandom);
        if (sel < 35) begin
            case ($urandom_range(3))
                0: return 8'(lo);
                1: return 8'(lo - 1);
                2: return 8'(hi);
                default: return 8'(hi + 1);
            endcase
        end
        return 8'($urandom_range(hi, lo));
    endfunction

    // This loads a whole glyph, its advance and one code that maps to it.
    task automatic load_glyph_burst();
        logic [7:0]  g;
        logic [15:0] d;
        g = 8'($urandom);
        for (int r = 0; r < ROWS; r++) begin
            case ($urandom_range(7))
                0: d = '0;
                1: d = '1;
                default: d = 16'($urandom);
            endcase
            send_load(bfb_pkg::REQ_LD_GLYPH, 12'(g * ROWS + r), d);
        end
        send_load(bfb_pkg::REQ_LD_ADV, 12'(g), 16'($urandom));
        d      = 16'($urandom);
        d[7:0] = g;
        send_load(bfb_pkg::REQ_LD_MAP, 12'($urandom_range(255, 1)), d);
    endtask

    // Any request kind, including unknown ones, with a random table index.
    task automatic noise_item();
        logic [bfb_pkg::REQ_W-1:0] kind;
        kind = bfb_pkg::REQ_W'($urandom);
        if (kind == bfb_pkg::REQ_START)
            send_start(16'($urandom), 8'($urandom), 8'($urandom));
        else if (kind == bfb_pkg::REQ_CHAR)
            send_char(pick_code());
        else if (kind >= REQ_UNKNOWN_FIRST)
            offer(kind, pack_req(16'($urandom), 8'($urandom), 8'($urandom), 8'd0,
                                 12'($urandom), 16'($urandom)));
        else
            send_load(kind, 12'($urandom), 16'($urandom));
    endtask

    task automatic random_phase(input int quota);
        int sent;
        int pick;
        int n;
        sent = ROWS + 2;
        load_glyph_burst();
        while (sent < quota) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                load_glyph_burst();
                sent += ROWS + 2;
            end else if (pick < 27) begin
                noise_item();
                sent++;
            end else begin
                send_start(16'($urandom), pick_row(), 8'($urandom));
                n = $urandom_range(6, 1);
                repeat (n) send_char(pick_code());
                sent += n + 1;
            end
        end
    endtask

    task automatic run_directed();
        logic [15:0] d;
        // Code zero gets a map entry so that it is never read unwritten.
        // Codes one and 255 both map to glyph 255. The upper data byte must be
        // dropped.
        send_load(bfb_pkg::REQ_LD_MAP, 12'd0, 16'h0000);
        send_load(bfb_pkg::REQ_LD_MAP, 12'd255, 16'hFFFF);
        send_load(bfb_pkg::REQ_LD_MAP, 12'd1, 16'h5AFF);
        send_load(bfb_pkg::REQ_LD_ADV, 12'd255, 16'hFF80);
        for (int r = 0; r < ROWS; r++) begin
            case (r)
                0: d = 16'hFFFF;
                1: d = 16'h0000;
                2: d = 16'h8000;
                3: d = 16'h0001;
                default: d = 16'($urandom);
            endcase
            send_load(bfb_pkg::REQ_LD_GLYPH, 12'(255 * ROWS + r), d);
        end
        // No start has been seen since reset, so nothing may be drawn yet.
        send_char(8'd255);
        // Loads past the end of each store, and an unknown kind, change nothing.
        send_load(bfb_pkg::REQ_LD_MAP, 12'hFFF, 16'h00AA);
        send_load(bfb_pkg::REQ_LD_ADV, 12'd256, 16'h0011);
        send_load(bfb_pkg::REQ_LD_GLYPH, 12'(STORE_ROWS), 16'h1234);
        offer('1, pack_req(16'($urandom), 8'($urandom), 8'($urandom), 8'd0,
                           12'($urandom), 16'($urandom)));
        // A row below the default band clips the whole string.
        send_start(16'hFFFF, 8'd200, 8'hFF);
        send_char(8'd255);
        // The last row of the band draws. The pen wraps past the top of the
        // offset range, and the advance is the most negative value.
        send_start(16'hFFFF, 8'd199, 8'hFF);
        send_char(8'd255);
        send_char(8'd0);
        send_char(8'd1);
        // Next comes the largest positive advance, starting from the origin.
        send_load(bfb_pkg::REQ_LD_ADV, 12'd255, 16'h007F);
        send_start(16'h0000, 8'd0, 8'h00);
        send_char(8'd1);
        send_char(8'd255);
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        wait_drained();
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct <= 61; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct <= 0;  rx_stall_pct <= 61; end
                default: begin tx_idle_pct <= 38; rx_stall_pct <= 38; end
            endcase
            case (phase)
                0: write_config(16'h0000, 8'd0, 8'd255);
                1: write_config(16'hFFFF, 8'd255, 8'd255);
                2: write_config(16'($urandom), 8'd20, 8'd180);
                3: write_config(16'($urandom), 8'($urandom), 8'($urandom));
                default: write_config(16'h8000, 8'd255, 8'd0);
            endcase
            if (phase == 0) begin
                // The receiver holds off for a long stretch while a full string
                // is offered. The row path fills up and the request side has to
                // wait. Every row in this band is drawable.
                hold_req <= hold_req + 1;
                send_start(16'($urandom), 8'($urandom), 8'($urandom));
                repeat (8) send_char(pick_code());
                wait_drained();
            end
            random_phase(PHASE_ITEMS);
            wait_drained();
        end
        $display("Run covered %0d strings (%0d clipped), %0d characters drawn,",
                 sb.strings, sb.clipped_strings, sb.chars_drawn);
        $display("%0d glyph rows compared and %0d table loads over five band settings.",
                 sb.rows_checked, sb.loads);
        if (sb.errors == 0) begin
            $display("bitmap_font_text_blitter_core verification clean");
        end else begin
            $display("bitmap_font_text_blitter_core verification failed");
        end
        $finish;
    end

endmodule
